// ----- hw/rtl/sensor_frame_parser_resync_macros.svh -----
// Assertion macros shared by the checker files of the frame parser.
`ifndef SENSOR_FRAME_PARSER_RESYNC_MACROS_SVH
`define SENSOR_FRAME_PARSER_RESYNC_MACROS_SVH

// Same-cycle implication, masked while reset is held.
`define SFPR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfpr assertion failed");

// Next-cycle implication, masked while reset is held.
`define SFPR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfpr assertion failed");

// Next-cycle implication that also covers the reset cycles.
`define SFPR_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("sfpr reset assertion failed");

`endif

// ----- hw/rtl/sfpr_pkg.sv -----
// Package of the frame parser: codes, reset values and fixed widths.
`default_nettype none
package sfpr_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned NUM_WORD_BYTES = 8;  // bytes 2..9 carry four words
  localparam int unsigned FIRST_WORD_BYTE = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_VALUE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KIND_PATTERN = 2'd1;

  localparam logic [BYTE_W-1:0] SYNC_VALUE_RST   = 8'h55;
  localparam logic [BYTE_W-1:0] KIND_PATTERN_RST = 8'h50;

  typedef enum logic {
    STATUS_FRAME  = 1'b0,
    STATUS_REJECT = 1'b1
  } status_t;

  typedef logic [BYTE_W-1:0] byte_t;

endpackage
`default_nettype wire

// ----- hw/rtl/sensor_frame_parser_resync.sv -----
// Top level of the sync-byte / checksum frame parser with byte resync.
//
// Use: feed received serial bytes on in_rx_byte with in_valid; a byte is
// taken at an edge where in_valid is high and in_stall is low. Each byte
// enters a shift line of FRAME_BYTES cells. Once FRAME_BYTES bytes are held
// the frame is checked (sync byte, type pattern, 8-bit checksum of all but
// the last byte against the last byte). A good frame gives a request with
// out_status = frame, the type byte and four signed little-endian words,
// and the line restarts empty. A bad frame gives a reject request with
// zero payload and the parser slides one byte, so it relocks within a frame.
// Bytes that only fill the line give no request.
// The request appears in the cycle after the byte that closes the frame.
// Throughput: one byte per cycle while in_stall is low; the check uses a
// running checksum register updated by one add and one subtract per byte.
// Stall: the result register holds its request while out_stall is high, and
// in_stall is raised only while a held request is stalled.
// Reset (rst_n low, synchronous): line and fill count cleared, config back
// to sync 0x55 and pattern 0x50, no request pending.
// Config: write cfg_wdata to register cfg_index with cfg_we, while idle.
`default_nettype none
module sensor_frame_parser_resync #(
  parameter int unsigned FRAME_BYTES = 11
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // configuration
  input  wire logic                               cfg_we,
  input  wire logic [sfpr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [sfpr_pkg::BYTE_W-1:0]        cfg_wdata,
  // input bytes
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [sfpr_pkg::BYTE_W-1:0]        in_rx_byte,
  // results
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    out_status,
  output logic [sfpr_pkg::BYTE_W-1:0]             out_frame_kind,
  output logic signed [sfpr_pkg::WORD_W-1:0]      out_word_a,
  output logic signed [sfpr_pkg::WORD_W-1:0]      out_word_b,
  output logic signed [sfpr_pkg::WORD_W-1:0]      out_word_c,
  output logic signed [sfpr_pkg::WORD_W-1:0]      out_word_d
);

  localparam int unsigned CNT_W = $clog2(FRAME_BYTES);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAME_BYTES - 1);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  sfpr_pkg::byte_t sync_r, sync_nxt;
  sfpr_pkg::byte_t kind_r, kind_nxt;

  always_comb begin
    sync_nxt = sync_r;
    kind_nxt = kind_r;
    if (cfg_we) begin
      case (cfg_index)
        sfpr_pkg::CFG_SYNC_VALUE:   sync_nxt = cfg_wdata;
        sfpr_pkg::CFG_KIND_PATTERN: kind_nxt = cfg_wdata;
        default: ;  // drop writes to unknown registers
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r <= sfpr_pkg::SYNC_VALUE_RST;
      kind_r <= sfpr_pkg::KIND_PATTERN_RST;
    end else begin
      sync_r <= sync_nxt;
      kind_r <= kind_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------
  logic out_valid_r, out_valid_nxt;
  logic in_acc;

  // Stall the input only while a finished request waits on the receiver.
  assign in_stall = out_valid_r & out_stall;
  assign in_acc   = in_valid & ~in_stall;

  // ---------------------------------------------------------------------
  // Shift line: cell 0 holds the oldest byte, the last cell the newest.
  // It always holds the most recent FRAME_BYTES bytes, which equals the
  // frame window whenever a full window is checked.
  // ---------------------------------------------------------------------
  sfpr_pkg::byte_t cell_q [FRAME_BYTES];

  for (genvar k = 0; k < FRAME_BYTES; k++) begin : g_cell
    if (k == FRAME_BYTES - 1) begin : g_tail
      sfpr_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (in_acc),
        .d        (in_rx_byte),
        .q        (cell_q[k])
      );
    end else begin : g_body
      sfpr_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (in_acc),
        .d        (cell_q[k+1]),
        .q        (cell_q[k])
      );
    end
  end

  // Running 8-bit sum of cells 0..FRAME_BYTES-2; after a shift those cells
  // are the old cells 1..FRAME_BYTES-1.
  sfpr_pkg::byte_t sum_r, sum_nxt;

  always_comb begin
    sum_nxt = sum_r - cell_q[0] + cell_q[FRAME_BYTES-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (in_acc) begin
      sum_r <= sum_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Fill count and frame check. The window after this byte is old cells
  // 1..FRAME_BYTES-1 followed by the incoming byte.
  // ---------------------------------------------------------------------
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             full;
  logic             frame_ok;

  assign full = (cnt_r == CNT_LAST);

  always_comb begin
    frame_ok = (cell_q[1] == sync_r) &&
               ((cell_q[2] & kind_r) == kind_r) &&
               (sum_nxt == in_rx_byte);
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_acc) begin
      if (!full) begin
        cnt_nxt = cnt_r + 1'b1;
      end else if (frame_ok) begin
        cnt_nxt = '0;          // restart empty after a good frame
      end else begin
        cnt_nxt = CNT_LAST;    // slide one byte, keep the rest
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Word bytes 2..9 of the window; a byte at or past the checksum reads 0.
  sfpr_pkg::byte_t wbyte [sfpr_pkg::NUM_WORD_BYTES];

  for (genvar j = 0; j < sfpr_pkg::NUM_WORD_BYTES; j++) begin : g_wbyte
    if (j + sfpr_pkg::FIRST_WORD_BYTE < FRAME_BYTES - 1) begin : g_live
      assign wbyte[j] = cell_q[j + sfpr_pkg::FIRST_WORD_BYTE + 1];
    end else begin : g_zero
      assign wbyte[j] = '0;
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  logic                              load;
  logic                              status_r;
  sfpr_pkg::byte_t                   kind_out_r;
  logic signed [sfpr_pkg::WORD_W-1:0] word_a_r, word_b_r, word_c_r, word_d_r;

  assign load = in_acc & full;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (frame_ok) begin
        status_r   <= sfpr_pkg::STATUS_FRAME;
        kind_out_r <= cell_q[2];
        word_a_r   <= {wbyte[1], wbyte[0]};
        word_b_r   <= {wbyte[3], wbyte[2]};
        word_c_r   <= {wbyte[5], wbyte[4]};
        word_d_r   <= {wbyte[7], wbyte[6]};
      end else begin
        status_r   <= sfpr_pkg::STATUS_REJECT;
        kind_out_r <= '0;
        word_a_r   <= '0;
        word_b_r   <= '0;
        word_c_r   <= '0;
        word_d_r   <= '0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_frame_kind = kind_out_r;
  assign out_word_a     = word_a_r;
  assign out_word_b     = word_b_r;
  assign out_word_c     = word_c_r;
  assign out_word_d     = word_d_r;

endmodule
`default_nettype wire

// ----- hw/rtl/sfpr_cell.sv -----
// One byte cell of the frame shift line.
`default_nettype none
module sfpr_cell (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          shift_en,
  input  wire sfpr_pkg::byte_t d,
  output sfpr_pkg::byte_t    q
);

  sfpr_pkg::byte_t data_r;
  sfpr_pkg::byte_t data_nxt;

  always_comb begin
    data_nxt = shift_en ? d : data_r;
  end

  // Clear on reset so the running checksum of the line starts consistent.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= '0;
    end else begin
      data_r <= data_nxt;
    end
  end

  assign q = data_r;

endmodule
`default_nettype wire

// ----- hw/rtl/sfpr_checker.sv -----
// Port-level checker of the frame parser and its bind.
`default_nettype none
`include "sensor_frame_parser_resync_macros.svh"
module sfpr_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_stall,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic                           out_status,
  input wire logic [sfpr_pkg::BYTE_W-1:0]    out_frame_kind,
  input wire logic signed [sfpr_pkg::WORD_W-1:0] out_word_a,
  input wire logic signed [sfpr_pkg::WORD_W-1:0] out_word_b,
  input wire logic signed [sfpr_pkg::WORD_W-1:0] out_word_c,
  input wire logic signed [sfpr_pkg::WORD_W-1:0] out_word_d
);

  // No request may survive reset.
  `SFPR_ASSERT_RST(a_reset_empty, !rst_n, !out_valid)

  // Input is held back only behind a stalled result.
  `SFPR_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall)

  // Reject requests carry an all-zero payload.
  `SFPR_ASSERT_IMP(a_reject_zero, out_valid && out_status == sfpr_pkg::STATUS_REJECT, out_frame_kind == '0 && out_word_a == '0 && out_word_b == '0 && out_word_c == '0 && out_word_d == '0)

  // A stalled request stays and keeps its payload.
  `SFPR_ASSERT_NXT(a_hold, out_valid && out_stall, out_valid && $stable(out_status) && $stable(out_frame_kind) && $stable(out_word_a) && $stable(out_word_b) && $stable(out_word_c) && $stable(out_word_d))

endmodule

bind sensor_frame_parser_resync sfpr_checker u_sfpr_checker (.*);
`default_nettype wire

// ----- bench/sensor_frame_parser_resync_tb.sv -----
// Self-checking bench for the sync-byte / checksum frame parser with byte resync.
`default_nettype none
module sensor_frame_parser_resync_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sfpr_pkg::*;

  localparam int unsigned FRAME_BYTES = 11;
  localparam int unsigned PHASES = 6;
  localparam int unsigned PHASE_BYTES = 180;
  localparam int unsigned DIR_ROWS = 23;
  localparam int unsigned IDLE_SLACK = 4;       // idle margin after the last owed request
  localparam int unsigned CYCLE_LIMIT = 400000;

  // The index port is wider than the register list; these two must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  typedef struct packed {
    status_t             status;
    byte_t               kind;
    logic [WORD_W-1:0]   wa;
    logic [WORD_W-1:0]   wb;
    logic [WORD_W-1:0]   wc;
    logic [WORD_W-1:0]   wd;
  } frame_res_t;

  // A request whose outcome is typed into the stimulus table.
  typedef struct packed {
    bit         pinned;
    frame_res_t res;
  } pin_t;

  typedef struct {
    byte_t      data;
    bit         pinned;
    frame_res_t res;
  } dir_row_t;

  typedef enum logic [1:0] {FLAW_NONE, FLAW_SYNC, FLAW_KIND, FLAW_SUM} flaw_t;
  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_t;

  localparam frame_res_t NO_FRAME   = '{STATUS_FRAME, 8'h00, 16'h0, 16'h0, 16'h0, 16'h0};
  localparam frame_res_t REJECT_RES = '{STATUS_REJECT, 8'h00, 16'h0, 16'h0, 16'h0, 16'h0};

  logic                clk;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  byte_t               cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  byte_t               in_rx_byte = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_status;
  byte_t               out_frame_kind;
  logic signed [WORD_W-1:0] out_word_a;
  logic signed [WORD_W-1:0] out_word_b;
  logic signed [WORD_W-1:0] out_word_c;
  logic signed [WORD_W-1:0] out_word_d;

  sensor_frame_parser_resync #(
    .FRAME_BYTES(FRAME_BYTES)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_rx_byte    (in_rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_frame_kind(out_frame_kind),
    .out_word_a    (out_word_a),
    .out_word_b    (out_word_b),
    .out_word_c    (out_word_c),
    .out_word_d    (out_word_d)
  );

  // Parser mirror: its own window, fill count and register copies.
  byte_t       frame_win [FRAME_BYTES] = '{default: 8'h00};
  int unsigned fill_cnt = 0;
  byte_t       want_sync = SYNC_VALUE_RST;
  byte_t       want_kind = KIND_PATTERN_RST;

  frame_res_t  frames_due [$];   // decoded frames and rejects still owed by the block
  pin_t        pin_q [$];        // typed outcomes of the directed rows, one per byte
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned bytes_sent = 0;
  int unsigned burst_left = 0;
  stall_mode_t stall_style = STALL_NONE;
  int unsigned stall_hold = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Little-endian word at byte lo; a byte at or past the checksum reads as zero.
  function automatic logic [WORD_W-1:0] word_from(input int unsigned lo);
    byte_t lsb;
    byte_t msb;
    lsb = (lo < FRAME_BYTES - 1) ? frame_win[lo] : 8'h00;
    msb = (lo + 1 < FRAME_BYTES - 1) ? frame_win[lo + 1] : 8'h00;
    return {msb, lsb};
  endfunction

  // Take one byte into the mirror window; return 1 when the window closes a check.
  function automatic bit absorb_byte(input byte_t b, output frame_res_t r);
    byte_t sum;
    r = REJECT_RES;
    if (fill_cnt >= FRAME_BYTES) fill_cnt = 0;
    frame_win[fill_cnt] = b;
    fill_cnt++;
    if (fill_cnt < FRAME_BYTES) return 1'b0;
    sum = '0;
    for (int i = 0; i < FRAME_BYTES - 1; i++) sum += frame_win[i];
    if (frame_win[0] != want_sync || (frame_win[1] & want_kind) != want_kind ||
        sum != frame_win[FRAME_BYTES - 1]) begin
      // Drop the oldest byte, keep the rest and slide on.
      for (int i = 0; i < FRAME_BYTES - 1; i++) frame_win[i] = frame_win[i + 1];
      fill_cnt = FRAME_BYTES - 1;
      return 1'b1;
    end
    r = '{STATUS_FRAME, frame_win[1], word_from(2), word_from(4), word_from(6), word_from(8)};
    fill_cnt = 0;
    return 1'b1;
  endfunction

  task automatic check_field(input string fname, input logic [WORD_W-1:0] want,
                             input logic [WORD_W-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %0h actual %0h", $time, fname, want, got);
      mismatches++;
    end
  endtask

  // Track accepted bytes and accepted requests, then choose the next stall.
  always @(posedge clk) begin
    frame_res_t res;
    frame_res_t want;
    pin_t       pin;
    bit         have;
    // Predict first, so a request that closed in this very cycle is already due.
    if (rst_n && in_valid && !in_stall) begin
      have = absorb_byte(in_rx_byte, res);
      if (pin_q.size() != 0) begin
        pin = pin_q.pop_front();
        if (pin.pinned) begin
          have = 1'b1;
          res = pin.res;
        end
      end
      if (have) frames_due.push_back(res);
    end
    if (rst_n && out_valid && !out_stall) begin
      if (frames_due.size() == 0) begin
        $display("%0t ns: request expected none actual status %0b kind %0h",
                 $time, out_status, out_frame_kind);
        mismatches++;
      end else begin
        want = frames_due.pop_front();
        check_field("status", WORD_W'(want.status), WORD_W'(out_status));
        check_field("frame_kind", WORD_W'(want.kind), WORD_W'(out_frame_kind));
        check_field("word_a", want.wa, out_word_a);
        check_field("word_b", want.wb, out_word_b);
        check_field("word_c", want.wc, out_word_c);
        check_field("word_d", want.wd, out_word_d);
      end
    end
    // Switch between no stall, sparse stall and mostly stalled after each random hold.
    if (stall_hold == 0) begin
      stall_style = stall_mode_t'($urandom_range(0, 2));
      stall_hold = $urandom_range(16, 80);
    end
    stall_hold--;
    case (stall_style)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      default:     out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Favor the word extremes so sign bits and full bytes show up often.
  function automatic byte_t pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h7F;
      3:       return 8'h80;
      default: return byte_t'($urandom_range(0, 255));
    endcase
  endfunction

  // Present one byte and hold it until taken; open a new burst with a gap when due.
  task automatic send_byte(input byte_t b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // Build a frame under the current registers, optionally with one flaw.
  task automatic send_frame(input flaw_t flaw);
    byte_t       fr [FRAME_BYTES];
    byte_t       sum;
    int unsigned bitn;
    fr[0] = want_sync;
    fr[1] = pick_byte() | want_kind;
    for (int i = 2; i < FRAME_BYTES - 1; i++) fr[i] = pick_byte();
    case (flaw)
      FLAW_SYNC: fr[0] = fr[0] ^ byte_t'($urandom_range(1, 255));
      FLAW_KIND: begin
        // Clear one required bit; with an empty pattern any type byte passes.
        if (want_kind != 8'h00) begin
          do bitn = $urandom_range(0, 7); while (!want_kind[bitn]);
          fr[1][bitn] = 1'b0;
        end
      end
      default: ;
    endcase
    sum = '0;
    for (int i = 0; i < FRAME_BYTES - 1; i++) sum += fr[i];
    fr[FRAME_BYTES - 1] = (flaw == FLAW_SUM) ? (sum ^ byte_t'($urandom_range(1, 255))) : sum;
    for (int i = 0; i < FRAME_BYTES; i++) send_byte(fr[i]);
  endtask

  // Stop sending and wait for every owed request, plus the block's latency.
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (frames_due.size() != 0) @(posedge clk);
    repeat (IDLE_SLACK) @(posedge clk);
  endtask

  // Write both registers, then hit the unused indexes with junk.
  task automatic program_regs(input byte_t sync_v, input byte_t kind_v);
    cfg_we <= 1'b1;
    cfg_index <= CFG_SYNC_VALUE;
    cfg_wdata <= sync_v;
    @(posedge clk);
    want_sync = sync_v;
    cfg_index <= CFG_KIND_PATTERN;
    cfg_wdata <= kind_v;
    @(posedge clk);
    want_kind = kind_v;
    cfg_index <= CFG_SPARE_LO;
    cfg_wdata <= byte_t'($urandom_range(0, 255));
    @(posedge clk);
    cfg_index <= CFG_SPARE_HI;
    cfg_wdata <= byte_t'($urandom_range(0, 255));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    dir_row_t    dir_tab [DIR_ROWS];
    byte_t       sync_v;
    byte_t       kind_v;
    int unsigned stop_at;
    int unsigned pick;

    // Reset values only: word extremes, then a stray byte, a reject and a relock.
    dir_tab = '{
      '{8'h55, 1'b0, NO_FRAME}, '{8'h53, 1'b0, NO_FRAME}, '{8'hFF, 1'b0, NO_FRAME},
      '{8'h7F, 1'b0, NO_FRAME}, '{8'h00, 1'b0, NO_FRAME}, '{8'h80, 1'b0, NO_FRAME},
      '{8'hFF, 1'b0, NO_FRAME}, '{8'hFF, 1'b0, NO_FRAME}, '{8'h00, 1'b0, NO_FRAME},
      '{8'h00, 1'b0, NO_FRAME},
      '{8'hA4, 1'b1, '{STATUS_FRAME, 8'h53, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000}},
      '{8'h00, 1'b0, NO_FRAME},
      '{8'h55, 1'b0, NO_FRAME}, '{8'h50, 1'b0, NO_FRAME}, '{8'h01, 1'b0, NO_FRAME},
      '{8'h00, 1'b0, NO_FRAME}, '{8'h02, 1'b0, NO_FRAME}, '{8'h00, 1'b0, NO_FRAME},
      '{8'h03, 1'b0, NO_FRAME}, '{8'h00, 1'b0, NO_FRAME}, '{8'h04, 1'b0, NO_FRAME},
      '{8'h00, 1'b1, REJECT_RES},
      '{8'hAF, 1'b1, '{STATUS_FRAME, 8'h50, 16'h0001, 16'h0002, 16'h0003, 16'h0004}}
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DIR_ROWS; r++) begin
      pin_q.push_back('{dir_tab[r].pinned, dir_tab[r].res});
      send_byte(dir_tab[r].data);
    end
    drain();

    // Random phases: reset values, both extremes, then arbitrary settings.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          sync_v = SYNC_VALUE_RST;
          kind_v = KIND_PATTERN_RST;
        end
        1: begin
          sync_v = 8'h00;
          kind_v = 8'h00;
        end
        2: begin
          sync_v = 8'hFF;
          kind_v = 8'hFF;
        end
        default: begin
          sync_v = byte_t'($urandom_range(0, 255));
          kind_v = byte_t'($urandom_range(0, 255));
        end
      endcase
      program_regs(sync_v, kind_v);
      stop_at = bytes_sent + PHASE_BYTES;
      while (bytes_sent < stop_at) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          send_frame(FLAW_NONE);
        end else if (pick < 85) begin
          send_frame(flaw_t'($urandom_range(1, 3)));
        end else begin
          // Line noise: knock the parser out of step.
          repeat ($urandom_range(1, 4)) send_byte(pick_byte());
        end
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
